// File: src/dfrh_pkg.sv
// Types and constants for the DfuSe request handler.
package dfrh_pkg;

   // Channel widths
   localparam int REQ_TDATA_W = 72;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 96;
   localparam int RSP_TUSER_W = 3;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Hardware length limit of the latched download length
   localparam int LEN_CAP = 2047;

   // Result queue
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   // DfuSe block-zero commands
   localparam logic [7:0] CMD_SET_ADDRESS = 8'h21;
   localparam logic [7:0] CMD_PAGE_ERASE  = 8'h41;

   // bwPollTimeout reported after a download block, in ms
   localparam logic [23:0] POLL_MS = 24'd10;

   // Data stage lengths of fixed replies
   localparam logic [15:0] STATUS_LEN   = 16'd6;
   localparam logic [15:0] STATE_LEN    = 16'd1;
   localparam logic [15:0] CMD_LIST_LEN = 16'd3;

   typedef enum logic [2:0] {
      REQ_DNLOAD      = 3'd0,
      REQ_UPLOAD      = 3'd1,
      REQ_GETSTATUS   = 3'd2,
      REQ_CLRSTATUS   = 3'd3,
      REQ_GETSTATE    = 3'd4,
      REQ_ABORT       = 3'd5,
      REQ_DETACH      = 3'd6,
      REQ_STATUS_DONE = 3'd7
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE          = 4'd2,
      ST_DNLOAD_SYNC   = 4'd3,
      ST_DNBUSY        = 4'd4,
      ST_DNLOAD_IDLE   = 4'd5,
      ST_MANIFEST_SYNC = 4'd6,
      ST_MANIFEST      = 4'd7,
      ST_UPLOAD_IDLE   = 4'd9,
      ST_ERROR         = 4'd10
   } dfu_state_type;

   typedef enum logic [2:0] {
      RK_NONE     = 3'd0,
      RK_STATUS   = 3'd1,
      RK_CMD_LIST = 3'd2,
      RK_FLASH    = 3'd3,
      RK_FILLER   = 3'd4
   } reply_kind_type;

   typedef enum logic [2:0] {
      FOP_NONE       = 3'd0,
      FOP_ERASE_PAGE = 3'd1,
      FOP_ERASE_APP  = 3'd2,
      FOP_PROGRAM    = 3'd3,
      FOP_READ       = 3'd4
   } flash_op_type;

   typedef enum logic [2:0] {
      CSR_APP_START    = 3'd0,
      CSR_WRITABLE_END = 3'd1,
      CSR_FLASH_END    = 3'd2,
      CSR_XFER_SIZE    = 3'd3,
      CSR_PAGE_LOG2    = 3'd4,
      CSR_UPLOAD_EN    = 3'd5
   } csr_index_type;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   typedef struct packed {
      reply_kind_type reply_kind;
      logic [15:0]    reply_length;
      logic           dfu_status;
      logic [23:0]    poll_timeout;
      logic [3:0]     state_code;
      flash_op_type   flash_op;
      logic [31:0]    flash_address;
      logic [10:0]    flash_length;
      logic           last_result;
   } rsp_type;

endpackage

// File: src/dfuse_request_handler_unit.sv
// DfuSe request handler: DFU state, address pointer and flash command generation.
//
//  channel | direction | tdata / data          | tuser / index | tlast
//  req_    | in        | block, length, cmd    | request type  | -
//  rsp_    | out       | reply and flash cmd   | reply kind    | last result
//  csr_    | in        | register write data   | register idx  | -
//
// A request is held in the input register and resolved there into one or two results,
// which enter a 4-entry result queue; rsp_tvalid rises in the cycle after.
// One request per cycle is sustained; the input register is released only when the queue
// has room for two results, so a stalled rsp_ side backs up into req_tready.
// Reset is synchronous: DFU state to dfuIDLE, pointers and flags cleared, registers to defaults.
module dfuse_request_handler_unit #(
   parameter int BUFFER_BYTES = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // block_num[15:0], data_length[31:16], cmd_byte[39:32], cmd_address[71:40]
   input  logic [dfrh_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type[2:0]
   input  logic [dfrh_pkg::REQ_TUSER_W-1:0]    req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // reply_length[15:0], dfu_status[16], poll_timeout[40:17], state_code[44:41],
   // flash_op[47:45], flash_address[79:48], flash_length[90:80], zero pad[95:91]
   output logic [dfrh_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // reply_kind[2:0]
   output logic [dfrh_pkg::RSP_TUSER_W-1:0]    rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dfrh_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [dfrh_pkg::CSR_DATA_W-1:0]     csr_data
);
   import dfrh_pkg::*;

   localparam int CapLen = (BUFFER_BYTES < LEN_CAP) ? BUFFER_BYTES : LEN_CAP;
   localparam logic [10:0] CAP_LEN = 11'(CapLen);

   // configuration
   logic [31:0] app_start_ff, writable_end_ff, flash_end_ff;
   logic [10:0] xfer_size_ff;
   logic [4:0]  page_log2_ff;
   logic        upload_en_ff;

   // input register
   logic         in_valid_ff;
   req_kind_type in_kind_ff;
   logic [15:0]  in_blk_ff, in_dlen_ff;
   logic [7:0]   in_cbyte_ff;
   logic [31:0]  in_caddr_ff;

   // protocol state
   dfu_state_type dfu_state_ff, dfu_state_in;
   logic [31:0]   addr_ptr_ff, addr_ptr_in;
   logic [15:0]   pend_blk_ff, pend_blk_in;
   logic [10:0]   pend_len_ff, pend_len_in;
   logic [7:0]    pend_cmd_ff, pend_cmd_in;
   logic [31:0]   pend_caddr_ff, pend_caddr_in;
   logic          app_erased_ff, app_erased_in;
   logic [23:0]   timeout_ff, timeout_in;

   // result queue
   rsp_type                fifo_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_CNT_W-1:0]  cnt_ff;

   logic          proc, req_acc, rsp_pop;
   logic          two_res;
   rsp_type       res_a, res_b, res_prog;

   // address and window checks
   logic [15:0]        mul_blk;
   logic signed [16:0] blk_off;
   logic signed [28:0] blk_prod;
   logic [31:0]        blk_addr;
   logic [10:0]        xfer_len;
   logic [10:0]        dl_capped;
   logic [31:0]        page_mask;
   logic               up_ok, prog_in_win, prog_fits, erase_ok;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         app_start_ff    <= 32'd134225920;
         writable_end_ff <= 32'd134283264;
         flash_end_ff    <= 32'd134283264;
         xfer_size_ff    <= 11'd1024;
         page_log2_ff    <= 5'd10;
         upload_en_ff    <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_APP_START:    app_start_ff    <= csr_data;
            CSR_WRITABLE_END: writable_end_ff <= csr_data;
            CSR_FLASH_END:    flash_end_ff    <= csr_data;
            CSR_XFER_SIZE:    xfer_size_ff    <= csr_data[10:0];
            CSR_PAGE_LOG2:    page_log2_ff    <= csr_data[4:0];
            CSR_UPLOAD_EN:    upload_en_ff    <= csr_data[0];
            default: ;
         endcase
      end
   end

   // queue must have room for two results before a request is resolved
   assign proc       = in_valid_ff && (cnt_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));
   assign req_tready = !in_valid_ff || proc;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_acc) begin
         in_valid_ff <= 1'b1;
      end else if (proc) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         in_kind_ff  <= req_kind_type'(req_tuser);
         in_blk_ff   <= req_tdata[15:0];
         in_dlen_ff  <= req_tdata[31:16];
         in_cbyte_ff <= req_tdata[39:32];
         in_caddr_ff <= req_tdata[71:40];
      end
   end

   // addr_ptr + (block - 2) * transfer_size, modulo 2^32
   assign mul_blk  = (in_kind_ff == REQ_STATUS_DONE) ? pend_blk_ff : in_blk_ff;
   assign blk_off  = $signed({1'b0, mul_blk}) - 17'sd2;
   assign blk_prod = blk_off * $signed({1'b0, xfer_size_ff});
   assign blk_addr = addr_ptr_ff + {{3{blk_prod[28]}}, blk_prod};

   assign xfer_len  = (xfer_size_ff > CAP_LEN) ? CAP_LEN : xfer_size_ff;
   assign dl_capped = (in_dlen_ff > 16'(CapLen)) ? CAP_LEN : in_dlen_ff[10:0];
   assign page_mask = ~(32'hFFFF_FFFF << page_log2_ff);

   assign up_ok = (blk_addr >= app_start_ff) &&
                  ({1'b0, blk_addr} + {22'd0, xfer_size_ff} <= {1'b0, flash_end_ff});
   assign prog_in_win = (blk_addr >= app_start_ff);
   assign prog_fits   = ({1'b0, blk_addr} + {22'd0, pend_len_ff} <= {1'b0, writable_end_ff});
   assign erase_ok    = (pend_caddr_ff >= app_start_ff) &&
                        ({1'b0, pend_caddr_ff} + {22'd0, xfer_size_ff}
                         <= {1'b0, writable_end_ff}) &&
                        ((pend_caddr_ff & page_mask) == 32'd0);

   // next state
   always_comb begin
      dfu_state_in  = dfu_state_ff;
      addr_ptr_in   = addr_ptr_ff;
      pend_blk_in   = pend_blk_ff;
      pend_len_in   = pend_len_ff;
      pend_cmd_in   = pend_cmd_ff;
      pend_caddr_in = pend_caddr_ff;
      app_erased_in = app_erased_ff;
      timeout_in    = timeout_ff;
      case (in_kind_ff)
         REQ_DNLOAD: begin
            if (in_dlen_ff == 16'd0) begin
               dfu_state_in = ST_MANIFEST_SYNC;
            end else begin
               pend_blk_in   = in_blk_ff;
               pend_len_in   = dl_capped;
               pend_cmd_in   = in_cbyte_ff;
               pend_caddr_in = in_caddr_ff;
               dfu_state_in  = ST_DNLOAD_SYNC;
            end
         end
         REQ_UPLOAD: begin
            if (in_blk_ff != 16'd0 && !upload_en_ff) dfu_state_in = ST_ERROR;
            else                                     dfu_state_in = ST_UPLOAD_IDLE;
         end
         REQ_GETSTATUS: begin
            if (dfu_state_ff == ST_DNLOAD_SYNC) begin
               dfu_state_in = ST_DNBUSY;
               timeout_in   = POLL_MS;
            end else if (dfu_state_ff == ST_MANIFEST_SYNC) begin
               dfu_state_in = ST_MANIFEST;
            end
         end
         REQ_CLRSTATUS: begin
            if (dfu_state_ff == ST_ERROR) dfu_state_in = ST_IDLE;
         end
         REQ_GETSTATE: ;
         REQ_ABORT:    dfu_state_in = ST_IDLE;
         REQ_DETACH:   dfu_state_in = ST_MANIFEST;
         REQ_STATUS_DONE: begin
            if (dfu_state_ff == ST_DNBUSY) begin
               if (pend_blk_ff == 16'd0) begin
                  if (pend_cmd_ff == CMD_SET_ADDRESS) addr_ptr_in = pend_caddr_ff;
                  dfu_state_in = ST_DNLOAD_IDLE;
               end else begin
                  app_erased_in = 1'b1;
                  // block in window but running past its end is an error
                  if (prog_in_win && !prog_fits) dfu_state_in = ST_ERROR;
                  else                           dfu_state_in = ST_DNLOAD_IDLE;
               end
            end
         end
         default: ;
      endcase
   end

   // results
   always_comb begin
      res_a             = '0;
      res_a.state_code  = dfu_state_in;
      res_a.last_result = 1'b1;
      res_b             = res_a;
      res_prog          = res_a;
      two_res           = 1'b0;
      case (in_kind_ff)
         REQ_UPLOAD: begin
            if (in_blk_ff == 16'd0) begin
               res_a.reply_kind   = RK_CMD_LIST;
               res_a.reply_length = CMD_LIST_LEN;
            end else if (upload_en_ff) begin
               res_a.reply_length = {5'd0, xfer_len};
               if (up_ok) begin
                  res_a.reply_kind    = RK_FLASH;
                  res_a.flash_op      = FOP_READ;
                  res_a.flash_address = blk_addr;
                  res_a.flash_length  = xfer_len;
               end else begin
                  res_a.reply_kind = RK_FILLER;
               end
            end
         end
         REQ_GETSTATUS: begin
            res_a.reply_kind   = RK_STATUS;
            res_a.reply_length = STATUS_LEN;
            res_a.dfu_status   = (dfu_state_ff == ST_ERROR) ? STATUS_ERR : STATUS_OK;
            res_a.poll_timeout = timeout_in;
         end
         REQ_GETSTATE: begin
            res_a.reply_kind   = RK_STATUS;
            res_a.reply_length = STATE_LEN;
         end
         REQ_STATUS_DONE: begin
            if (dfu_state_ff == ST_DNBUSY) begin
               if (pend_blk_ff == 16'd0) begin
                  if (pend_cmd_ff == CMD_PAGE_ERASE && erase_ok) begin
                     res_a.flash_op      = FOP_ERASE_PAGE;
                     res_a.flash_address = pend_caddr_ff;
                  end
               end else begin
                  if (prog_in_win && prog_fits) begin
                     res_prog.flash_op      = FOP_PROGRAM;
                     res_prog.flash_address = blk_addr;
                     res_prog.flash_length  = pend_len_ff;
                  end
                  // first data block erases the whole application area up front
                  if (!app_erased_ff) begin
                     two_res             = 1'b1;
                     res_a.flash_op      = FOP_ERASE_APP;
                     res_a.flash_address = app_start_ff;
                     res_a.last_result   = 1'b0;
                     res_b               = res_prog;
                  end else begin
                     res_a = res_prog;
                  end
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dfu_state_ff  <= ST_IDLE;
         addr_ptr_ff   <= '0;
         pend_blk_ff   <= '0;
         pend_len_ff   <= '0;
         pend_cmd_ff   <= '0;
         pend_caddr_ff <= '0;
         app_erased_ff <= 1'b0;
         timeout_ff    <= '0;
      end else if (proc) begin
         dfu_state_ff  <= dfu_state_in;
         addr_ptr_ff   <= addr_ptr_in;
         pend_blk_ff   <= pend_blk_in;
         pend_len_ff   <= pend_len_in;
         pend_cmd_ff   <= pend_cmd_in;
         pend_caddr_ff <= pend_caddr_in;
         app_erased_ff <= app_erased_in;
         timeout_ff    <= timeout_in;
      end
   end

   // result queue
   assign rsp_pop = rsp_tvalid && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (proc) wr_ptr_ff <= wr_ptr_ff + (two_res ? FIFO_PTR_W'(2) : FIFO_PTR_W'(1));
         if (rsp_pop) rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         cnt_ff <= cnt_ff
                   + (proc ? (two_res ? FIFO_CNT_W'(2) : FIFO_CNT_W'(1)) : FIFO_CNT_W'(0))
                   - (rsp_pop ? FIFO_CNT_W'(1) : FIFO_CNT_W'(0));
      end
   end

   always_ff @(posedge clock) begin
      if (proc) begin
         fifo_ff[wr_ptr_ff] <= res_a;
         if (two_res) fifo_ff[wr_ptr_ff + FIFO_PTR_W'(1)] <= res_b;
      end
   end

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tuser  = fifo_ff[rd_ptr_ff].reply_kind;
   assign rsp_tlast  = fifo_ff[rd_ptr_ff].last_result;
   assign rsp_tdata  = {5'd0,
                        fifo_ff[rd_ptr_ff].flash_length,
                        fifo_ff[rd_ptr_ff].flash_address,
                        fifo_ff[rd_ptr_ff].flash_op,
                        fifo_ff[rd_ptr_ff].state_code,
                        fifo_ff[rd_ptr_ff].poll_timeout,
                        fifo_ff[rd_ptr_ff].dfu_status,
                        fifo_ff[rd_ptr_ff].reply_length};

endmodule

// File: test/tb_dfuse_request_handler_unit.sv
// Self-checking testbench for the DfuSe request handler: random and directed requests.
`timescale 1ns / 100ps

module tb_dfuse_request_handler_unit;
   import dfrh_pkg::*;

   localparam int BUF_BYTES = 1024;

   typedef struct {
      req_kind_type kind;
      logic [15:0]  blk;
      logic [15:0]  dlen;
      logic [7:0]   cbyte;
      logic [31:0]  caddr;
   } ctrl_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   dfuse_request_handler_unit #(.BUFFER_BYTES(BUF_BYTES)) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   // register shadows, reset values
   logic [31:0] cfg_app_start  = 32'h0800_2000;
   logic [31:0] cfg_wr_end     = 32'h0801_0000;
   logic [31:0] cfg_flash_end  = 32'h0801_0000;
   logic [10:0] cfg_xfer       = 11'd1024;
   logic [4:0]  cfg_page_log2  = 5'd10;
   logic        cfg_upload_en  = 1'b0;

   // DFU state mirror
   dfu_state_type fsm_state     = ST_IDLE;
   logic [31:0]   addr_ptr      = '0;
   logic [15:0]   pend_block    = '0;
   logic [10:0]   pend_len      = '0;
   logic [7:0]    pend_cmd      = '0;
   logic [31:0]   pend_cmd_addr = '0;
   logic          app_erased    = 1'b0;
   logic [23:0]   poll_val      = '0;

   ctrl_req_type req_backlog[$];
   ctrl_req_type req_cur;
   rsp_type      rsp_expected[$];

   int gap_pct = 0;
   int stall_pct = 0;
   int errors = 0;
   int n_requests = 0;
   int n_results = 0;
   int n_settings = 0;
   int op_seen[5] = '{default: 0};

   function automatic logic [31:0] block_addr(input logic [15:0] blk);
      return addr_ptr + (32'(blk) - 32'd2) * 32'(cfg_xfer);
   endfunction

   // Update the state mirror for one request and queue the results it causes.
   task automatic resolve_request(input ctrl_req_type r);
      rsp_type     res;
      rsp_type     erase_res;
      logic [31:0] a;
      logic [15:0] len16;
      logic [63:0] mask;
      logic        erase_now;
      res = '0;
      erase_now = 1'b0;
      res.last_result = 1'b1;
      case (r.kind)
         REQ_DNLOAD: begin
            if (r.dlen == 16'd0) begin
               fsm_state = ST_MANIFEST_SYNC;
            end else begin
               len16 = r.dlen;
               if (len16 > BUF_BYTES) len16 = 16'(BUF_BYTES);
               if (len16 > LEN_CAP) len16 = 16'(LEN_CAP);
               pend_block = r.blk;
               pend_len = len16[10:0];
               pend_cmd = r.cbyte;
               pend_cmd_addr = r.caddr;
               fsm_state = ST_DNLOAD_SYNC;
            end
         end
         REQ_UPLOAD: begin
            fsm_state = ST_UPLOAD_IDLE;
            if (r.blk == 16'd0) begin
               res.reply_kind = RK_CMD_LIST;
               res.reply_length = CMD_LIST_LEN;
            end else if (!cfg_upload_en) begin
               fsm_state = ST_ERROR;
            end else begin
               a = block_addr(r.blk);
               len16 = (cfg_xfer < BUF_BYTES) ? 16'(cfg_xfer) : 16'(BUF_BYTES);
               res.reply_length = len16;
               if (a >= cfg_app_start &&
                   {1'b0, a} + 33'(cfg_xfer) <= {1'b0, cfg_flash_end}) begin
                  res.reply_kind = RK_FLASH;
                  res.flash_op = FOP_READ;
                  res.flash_address = a;
                  res.flash_length = len16[10:0];
               end else begin
                  res.reply_kind = RK_FILLER;
               end
            end
         end
         REQ_GETSTATUS: begin
            res.dfu_status = STATUS_OK;
            if (fsm_state == ST_DNLOAD_SYNC) begin
               fsm_state = ST_DNBUSY;
               poll_val = POLL_MS;
            end else if (fsm_state == ST_MANIFEST_SYNC) begin
               fsm_state = ST_MANIFEST;
            end else if (fsm_state == ST_ERROR) begin
               res.dfu_status = STATUS_ERR;
            end
            res.reply_kind = RK_STATUS;
            res.reply_length = STATUS_LEN;
            res.poll_timeout = poll_val;
         end
         REQ_CLRSTATUS: begin
            if (fsm_state == ST_ERROR) fsm_state = ST_IDLE;
         end
         REQ_GETSTATE: begin
            res.reply_kind = RK_STATUS;
            res.reply_length = STATE_LEN;
         end
         REQ_ABORT:  fsm_state = ST_IDLE;
         REQ_DETACH: fsm_state = ST_MANIFEST;
         default: begin
            // status read completed: only acts while a block is pending
            if (fsm_state == ST_DNBUSY) begin
               if (pend_block == 16'd0) begin
                  if (pend_cmd == CMD_PAGE_ERASE) begin
                     a = pend_cmd_addr;
                     mask = (64'd1 << cfg_page_log2) - 64'd1;
                     if (a >= cfg_app_start &&
                         {1'b0, a} + 33'(cfg_xfer) <= {1'b0, cfg_wr_end} &&
                         (64'(a) & mask) == 64'd0) begin
                        res.flash_op = FOP_ERASE_PAGE;
                        res.flash_address = a;
                     end
                  end else if (pend_cmd == CMD_SET_ADDRESS) begin
                     addr_ptr = pend_cmd_addr;
                  end
                  fsm_state = ST_DNLOAD_IDLE;
               end else begin
                  a = block_addr(pend_block);
                  erase_now = !app_erased;
                  app_erased = 1'b1;
                  if (a >= cfg_app_start) begin
                     if ({1'b0, a} + 33'(pend_len) <= {1'b0, cfg_wr_end}) begin
                        res.flash_op = FOP_PROGRAM;
                        res.flash_address = a;
                        res.flash_length = pend_len;
                        fsm_state = ST_DNLOAD_IDLE;
                     end else begin
                        fsm_state = ST_ERROR;
                     end
                  end else begin
                     fsm_state = ST_DNLOAD_IDLE;
                  end
               end
            end
         end
      endcase
      res.state_code = fsm_state;
      if (erase_now) begin
         erase_res = '0;
         erase_res.flash_op = FOP_ERASE_APP;
         erase_res.flash_address = cfg_app_start;
         erase_res.state_code = fsm_state;
         rsp_expected.push_back(erase_res);
      end
      rsp_expected.push_back(res);
   endtask

   // request driver
   always @(posedge clock) begin
      logic busy;
      busy = req_tvalid;
      if (req_tvalid && req_tready) begin
         resolve_request(req_cur);
         n_requests++;
         busy = 1'b0;
      end
      if (!reset && !busy) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
            req_cur = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata <= {req_cur.caddr, req_cur.cbyte, req_cur.dlen, req_cur.blk};
            req_tuser <= req_cur.kind;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      end
   endfunction

   // result monitor
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.reply_kind    = reply_kind_type'(rsp_tuser);
         got.reply_length  = rsp_tdata[15:0];
         got.dfu_status    = rsp_tdata[16];
         got.poll_timeout  = rsp_tdata[40:17];
         got.state_code    = rsp_tdata[44:41];
         got.flash_op      = flash_op_type'(rsp_tdata[47:45]);
         got.flash_address = rsp_tdata[79:48];
         got.flash_length  = rsp_tdata[90:80];
         got.last_result   = rsp_tlast;
         n_results++;
         if (rsp_expected.size() == 0) begin
            errors++;
            $display("%0t: unexpected result, expected none, got %h", $time, got);
         end else begin
            want = rsp_expected.pop_front();
            check_field("reply_kind", want.reply_kind, got.reply_kind);
            check_field("reply_length", want.reply_length, got.reply_length);
            check_field("dfu_status", want.dfu_status, got.dfu_status);
            check_field("poll_timeout", want.poll_timeout, got.poll_timeout);
            check_field("state_code", want.state_code, got.state_code);
            check_field("flash_op", want.flash_op, got.flash_op);
            check_field("flash_address", want.flash_address, got.flash_address);
            check_field("flash_length", want.flash_length, got.flash_length);
            check_field("last_result", want.last_result, got.last_result);
            if (want.flash_op <= FOP_READ) op_seen[want.flash_op]++;
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_APP_START:    cfg_app_start = val;
         CSR_WRITABLE_END: cfg_wr_end = val;
         CSR_FLASH_END:    cfg_flash_end = val;
         CSR_XFER_SIZE:    cfg_xfer = val[10:0];
         CSR_PAGE_LOG2:    cfg_page_log2 = val[4:0];
         CSR_UPLOAD_EN:    cfg_upload_en = val[0];
         default: ;
      endcase
   endtask

   task automatic set_config(input logic [31:0] app, input logic [31:0] wend,
                             input logic [31:0] fend, input logic [10:0] xfer,
                             input logic [4:0] plog2, input logic upen);
      write_reg(CSR_APP_START, app);
      write_reg(CSR_WRITABLE_END, wend);
      write_reg(CSR_FLASH_END, fend);
      write_reg(CSR_XFER_SIZE, 32'(xfer));
      write_reg(CSR_PAGE_LOG2, 32'(plog2));
      write_reg(CSR_UPLOAD_EN, 32'(upen));
      n_settings++;
   endtask

   // every request yields a result, so a short pause after the last one is enough
   task automatic wait_drained();
      do @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || rsp_expected.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic push_req(input req_kind_type kind, input logic [15:0] blk,
                           input logic [15:0] dlen, input logic [7:0] cbyte,
                           input logic [31:0] caddr);
      ctrl_req_type r;
      r.kind = kind;
      r.blk = blk;
      r.dlen = dlen;
      r.cbyte = cbyte;
      r.caddr = caddr;
      req_backlog.push_back(r);
   endtask

   // addresses clustered around the window edges of the current setting
   function automatic logic [31:0] pick_addr();
      case ($urandom_range(5))
         0: return cfg_app_start;
         1: return cfg_app_start + (32'($urandom_range(15)) << cfg_page_log2);
         2: return cfg_wr_end - 32'($urandom_range(2100));
         3: return cfg_app_start - 32'($urandom_range(1, 2048));
         4: return cfg_app_start + 32'($urandom_range(1, 3000));
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_length();
      case ($urandom_range(9))
         0: return 16'($urandom);
         1: return 16'(BUF_BYTES);
         2: return 16'd1;
         default: return 16'($urandom_range(1, 1100));
      endcase
   endfunction

   task automatic queue_random_traffic(input int count);
      int          added;
      int          sel;
      logic [15:0] blk;
      logic [15:0] dlen;
      logic [7:0]  cb;
      added = 0;
      while (added < count) begin
         sel = $urandom_range(99);
         if (sel < 45) begin
            // download block, status read, completion
            cb = 8'($urandom);
            case ($urandom_range(9))
               0, 1: begin blk = 16'd0; cb = CMD_SET_ADDRESS; end
               2, 3: begin blk = 16'd0; cb = CMD_PAGE_ERASE; end
               4:    blk = 16'd0;
               9:    blk = 16'($urandom);
               default: blk = 16'($urandom_range(2, 14));
            endcase
            dlen = ($urandom_range(19) == 0) ? 16'd0 : pick_length();
            push_req(REQ_DNLOAD, blk, dlen, cb, pick_addr());
            push_req(REQ_GETSTATUS, 16'($urandom), 16'($urandom), 8'($urandom), $urandom);
            added += 2;
            if ($urandom_range(9) != 0) begin
               push_req(REQ_STATUS_DONE, 16'($urandom), 16'($urandom), 8'($urandom),
                        $urandom);
               added++;
            end
            if ($urandom_range(4) == 0) begin
               push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
               added++;
            end
         end else if (sel < 60) begin
            blk = ($urandom_range(9) < 7) ? 16'($urandom_range(40)) : 16'($urandom);
            push_req(REQ_UPLOAD, blk, pick_length(), 8'($urandom), $urandom);
            added++;
         end else if (sel < 75) begin
            push_req(req_kind_type'($urandom_range(2, 4)), 16'($urandom), 16'($urandom),
                     8'($urandom), $urandom);
            added++;
         end else if (sel < 82) begin
            push_req(($urandom_range(1) != 0) ? REQ_ABORT : REQ_DETACH, 16'($urandom),
                     16'($urandom), 8'($urandom), $urandom);
            added++;
         end else begin
            push_req(req_kind_type'($urandom_range(7)), 16'($urandom), 16'($urandom),
                     8'($urandom), $urandom);
            added++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed sequence on a typical layout
      set_config(32'h0800_2000, 32'h0801_0000, 32'h0802_0000, 11'd1024, 5'd10, 1'b1);
      push_req(REQ_UPLOAD, 16'd0, 16'd3, 8'd0, 32'd0);
      push_req(REQ_DNLOAD, 16'd0, 16'd5, CMD_SET_ADDRESS, 32'h0800_2000);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_STATUS_DONE, 16'd0, 16'd0, 8'd0, 32'd0);
      // first data block: whole area erase, then a saturated program
      push_req(REQ_DNLOAD, 16'd2, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_STATUS_DONE, 16'd0, 16'd0, 8'd0, 32'd0);
      push_req(REQ_DNLOAD, 16'd0, 16'd5, CMD_PAGE_ERASE, 32'h0800_2400);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_STATUS_DONE, 16'd0, 16'd0, 8'd0, 32'd0);
      // misaligned page erase is dropped
      push_req(REQ_DNLOAD, 16'd0, 16'd5, CMD_PAGE_ERASE, 32'h0800_2401);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_STATUS_DONE, 16'd0, 16'd0, 8'd0, 32'd0);
      // block starting past the window end: error state
      push_req(REQ_DNLOAD, 16'd60, 16'd1, 8'd0, 32'd0);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_STATUS_DONE, 16'hFFFF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_CLRSTATUS, 16'd0, 16'd0, 8'd0, 32'd0);
      push_req(REQ_UPLOAD, 16'd2, 16'd1024, 8'd0, 32'd0);
      push_req(REQ_UPLOAD, 16'hFFFF, 16'd1024, 8'd0, 32'd0);
      push_req(REQ_GETSTATE, 16'd0, 16'd1, 8'd0, 32'd0);
      push_req(REQ_STATUS_DONE, 16'd0, 16'd0, 8'd0, 32'd0);
      push_req(REQ_DNLOAD, 16'd0, 16'd0, 8'd0, 32'd0);
      push_req(REQ_GETSTATUS, 16'd0, 16'd6, 8'd0, 32'd0);
      push_req(REQ_DETACH, 16'd0, 16'd0, 8'd0, 32'd0);
      push_req(REQ_ABORT, 16'd0, 16'd0, 8'd0, 32'd0);
      wait_drained();

      // random phases, each with its own layout, under varied flow control
      set_config(32'h0800_2000, 32'h0801_0000, 32'h0801_0000, 11'd1024, 5'd10, 1'b0);
      queue_random_traffic(300);
      wait_drained();

      set_config(32'h0000_1000, 32'h0000_3000, 32'h0000_4000, 11'd64, 5'd6, 1'b1);
      gap_pct = 46;
      queue_random_traffic(300);
      wait_drained();

      set_config(32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd1024, 5'd16, 1'b1);
      gap_pct = 0;
      stall_pct = 46;
      queue_random_traffic(300);
      wait_drained();

      set_config(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 11'd0, 5'd0, 1'b0);
      gap_pct = 35;
      stall_pct = 35;
      queue_random_traffic(300);
      wait_drained();

      // unaligned window end, so blocks can straddle it
      set_config(32'h0800_0000, 32'h0800_FF00, 32'h0801_0000, 11'd1000, 5'd12, 1'b1);
      queue_random_traffic(300);
      wait_drained();

      set_config(32'h0000_0020, 32'h0000_0200, 32'h0000_0180, 11'd1, 5'd4, 1'b1);
      gap_pct = 0;
      stall_pct = 0;
      queue_random_traffic(300);
      wait_drained();
      repeat (16) @(posedge clock);

      $display("Summary: %0d requests, %0d results checked over %0d register settings",
               n_requests, n_results, n_settings);
      $display("Flash commands: %0d page erase, %0d area erase, %0d program, %0d read",
               op_seen[FOP_ERASE_PAGE], op_seen[FOP_ERASE_APP], op_seen[FOP_PROGRAM],
               op_seen[FOP_READ]);
      if (errors == 0 && rsp_expected.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout with %0d results outstanding", $time, rsp_expected.size());
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
